[rtl/dds_pkg.sv]
package dds_pkg;

   // width of the filter state, signed Q16.16
   localparam int SPEED_WIDTH = 32;

   localparam int WHEEL_W = 32;
   localparam int NEG_W   = WHEEL_W + 1;                 // negated right wheel, exact
   localparam int SUM_W   = WHEEL_W + 2;                 // sum / difference of the wheels
   localparam int LIN_W   = WHEEL_W + 1;                 // half the sum
   localparam int MAG_W   = SUM_W;                       // magnitude of the difference
   localparam int DIFF_W  = ((SPEED_WIDTH > LIN_W) ? SPEED_WIDTH : LIN_W) + 1;
   localparam int MUL_A_W = ((DIFF_W > MAG_W) ? DIFF_W : MAG_W) + 1;
   localparam int MUL_B_W = 18;
   localparam int PROD_W  = MUL_A_W + MUL_B_W;
   localparam int RATE_W  = MAG_W + 17;                  // mag * hi + (mag * lo >> 16)
   localparam int WIDE_W  = PROD_W;

   localparam int ALPHA_W = 17;
   localparam int ITW_W   = 32;
   localparam int DB_W    = 31;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [ALPHA_W-1:0] ALPHA_ONE = 17'd65536;
   localparam int MILLI_SCALE = 1000;

   localparam logic [CSR_IDX_W-1:0] CSR_LINEAR_ALPHA      = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ROTATION_ALPHA    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_INV_TRACK_WIDTH   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_ROTATION_DEADBAND = 3'd3;

   localparam logic [ALPHA_W-1:0] LINEAR_ALPHA_RESET      = 17'd13107;
   localparam logic [ALPHA_W-1:0] ROTATION_ALPHA_RESET    = 17'd13107;
   localparam logic [ITW_W-1:0]   INV_TRACK_WIDTH_RESET   = 32'd65536;
   localparam logic [DB_W-1:0]    ROTATION_DEADBAND_RESET = 31'd655;

   typedef struct packed {
      logic [ALPHA_W-1:0] linear_alpha;
      logic [ALPHA_W-1:0] rotation_alpha;
      logic [ITW_W-1:0]   inv_track_width;
      logic [DB_W-1:0]    rotation_deadband;
   } cfg_type;

   typedef struct packed {
      logic                      en;
      logic signed [MUL_A_W-1:0] a;
      logic signed [MUL_B_W-1:0] b;
   } mul_req_type;

endpackage

[rtl/dds_if.sv]
interface dds_req_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] right_wheel_raw;
   logic signed [31:0] left_wheel_raw;

   modport source (output valid, output right_wheel_raw, output left_wheel_raw, input ready);
   modport sink (input valid, input right_wheel_raw, input left_wheel_raw, output ready);
endinterface

interface dds_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] right_wheel_speed;
   logic signed [31:0] left_wheel_speed;
   logic signed [31:0] body_speed_milli;
   logic signed [31:0] body_rotation_milli;

   modport source (output valid, output right_wheel_speed, output left_wheel_speed,
                   output body_speed_milli, output body_rotation_milli, input ready);
   modport sink (input valid, input right_wheel_speed, input left_wheel_speed,
                 input body_speed_milli, input body_rotation_milli, output ready);
endinterface

[rtl/dds_csr.sv]
module dds_csr
   import dds_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output cfg_type               cfg
);

   cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_LINEAR_ALPHA:      cfg_in.linear_alpha      = csr_wdata[ALPHA_W-1:0];
            CSR_ROTATION_ALPHA:    cfg_in.rotation_alpha    = csr_wdata[ALPHA_W-1:0];
            CSR_INV_TRACK_WIDTH:   cfg_in.inv_track_width   = csr_wdata[ITW_W-1:0];
            CSR_ROTATION_DEADBAND: cfg_in.rotation_deadband = csr_wdata[DB_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.linear_alpha      <= LINEAR_ALPHA_RESET;
         cfg_ff.rotation_alpha    <= ROTATION_ALPHA_RESET;
         cfg_ff.inv_track_width   <= INV_TRACK_WIDTH_RESET;
         cfg_ff.rotation_deadband <= ROTATION_DEADBAND_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

[rtl/dds_mul.sv]
module dds_mul
   import dds_pkg::*;
(
   input  logic                     clock,
   input  mul_req_type              op,
   output logic signed [PROD_W-1:0] prod
);

   logic signed [PROD_W-1:0] prod_ff, prod_in;

   assign prod_in = op.a * op.b;

   // product holds until the next issued operation
   always_ff @(posedge clock) begin
      if (op.en) begin
         prod_ff <= prod_in;
      end
   end

   assign prod = prod_ff;

endmodule

[rtl/dds_core.sv]
module dds_core
   import dds_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  cfg_type                  cfg,
   dds_req_if.sink                  req_chan,
   dds_rsp_if.source                rsp_chan,
   output mul_req_type              mul_op,
   input  logic signed [PROD_W-1:0] mul_prod
);

   localparam logic [3:0] ST_IDLE = 4'd0;
   localparam logic [3:0] ST_PREP = 4'd1;
   localparam logic [3:0] ST_MLO  = 4'd2;
   localparam logic [3:0] ST_MHI  = 4'd3;
   localparam logic [3:0] ST_LIN  = 4'd4;
   localparam logic [3:0] ST_ROT  = 4'd5;
   localparam logic [3:0] ST_ML   = 4'd6;
   localparam logic [3:0] ST_MR   = 4'd7;
   localparam logic [3:0] ST_OUT  = 4'd8;

   function automatic logic signed [SPEED_WIDTH-1:0] sat_avg(input logic signed [WIDE_W-1:0] v);
      logic ovf;
      ovf = !((&v[WIDE_W-1:SPEED_WIDTH-1]) || !(|v[WIDE_W-1:SPEED_WIDTH-1]));
      if (!ovf) return v[SPEED_WIDTH-1:0];
      return v[WIDE_W-1] ? {1'b1, {(SPEED_WIDTH-1){1'b0}}} : {1'b0, {(SPEED_WIDTH-1){1'b1}}};
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [WIDE_W-1:0] v);
      logic ovf;
      ovf = !((&v[WIDE_W-1:31]) || !(|v[WIDE_W-1:31]));
      if (!ovf) return v[31:0];
      return v[WIDE_W-1] ? {1'b1, {31{1'b0}}} : {1'b0, {31{1'b1}}};
   endfunction

   // divide by 65536, rounding toward zero
   function automatic logic signed [WIDE_W-1:0] tz16(input logic signed [WIDE_W-1:0] p);
      logic signed [WIDE_W-1:0] adj;
      adj = p[WIDE_W-1] ? p + WIDE_W'(65535) : p;
      return adj >>> 16;
   endfunction

   logic [3:0]                    state_ff, state_in;
   logic signed [NEG_W-1:0]       wr_ff, wr_in;
   logic signed [WHEEL_W-1:0]     wl_ff, wl_in;
   logic signed [LIN_W-1:0]       lin_raw_ff, lin_raw_in;
   logic [MAG_W-1:0]              mag_ff, mag_in;
   logic                          neg_ff, neg_in;
   logic [MAG_W-1:0]              acc_ff, acc_in;
   logic signed [SPEED_WIDTH-1:0] rot_raw_ff, rot_raw_in;
   logic signed [SPEED_WIDTH-1:0] ylin_ff, ylin_in;
   logic signed [SPEED_WIDTH-1:0] yrot_ff, yrot_in;
   logic signed [31:0]            speed_milli_ff, speed_milli_in;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic signed [31:0]            out_right_ff, out_right_in;
   logic signed [31:0]            out_left_ff, out_left_in;
   logic signed [31:0]            out_speed_ff, out_speed_in;
   logic signed [31:0]            out_rot_ff, out_rot_in;

   logic signed [SUM_W-1:0]       sum_w, sum_adj, diff_w;
   logic [RATE_W-1:0]             rate_u;
   logic signed [WIDE_W-1:0]      rate_s, ema_sum;
   logic signed [DIFF_W-1:0]      d_w;
   logic [WIDE_W-1:0]             yrot_mag;
   logic                          in_band;
   logic [ALPHA_W-1:0]            alpha_lin, alpha_rot;
   logic                          out_load;

   assign alpha_lin = (cfg.linear_alpha > ALPHA_ONE) ? ALPHA_ONE : cfg.linear_alpha;
   assign alpha_rot = (cfg.rotation_alpha > ALPHA_ONE) ? ALPHA_ONE : cfg.rotation_alpha;

   assign out_load = (state_ff == ST_OUT) && (!rsp_valid_ff || rsp_chan.ready);

   always_comb begin
      state_in       = state_ff;
      wr_in          = wr_ff;
      wl_in          = wl_ff;
      lin_raw_in     = lin_raw_ff;
      mag_in         = mag_ff;
      neg_in         = neg_ff;
      acc_in         = acc_ff;
      rot_raw_in     = rot_raw_ff;
      ylin_in        = ylin_ff;
      yrot_in        = yrot_ff;
      speed_milli_in = speed_milli_ff;
      out_right_in   = out_right_ff;
      out_left_in    = out_left_ff;
      out_speed_in   = out_speed_ff;
      out_rot_in     = out_rot_ff;
      mul_op.en      = 1'b0;
      mul_op.a       = '0;
      mul_op.b       = '0;

      sum_w    = SUM_W'(wr_ff) + SUM_W'(wl_ff);
      sum_adj  = sum_w[SUM_W-1] ? sum_w + SUM_W'(1) : sum_w;
      diff_w   = SUM_W'(wr_ff) - SUM_W'(wl_ff);
      rate_u   = RATE_W'(mul_prod) + RATE_W'(acc_ff);
      rate_s   = neg_ff ? -WIDE_W'(rate_u) : WIDE_W'(rate_u);
      ema_sum  = '0;
      d_w      = '0;
      yrot_mag = yrot_ff[SPEED_WIDTH-1] ? -WIDE_W'(yrot_ff) : WIDE_W'(yrot_ff);
      in_band  = yrot_mag < WIDE_W'(cfg.rotation_deadband);

      case (state_ff)
         ST_IDLE: begin
            if (req_chan.valid) begin
               wr_in    = -(NEG_W'(req_chan.right_wheel_raw));
               wl_in    = req_chan.left_wheel_raw;
               state_in = ST_PREP;
            end
         end
         ST_PREP: begin
            lin_raw_in = LIN_W'(sum_adj >>> 1);
            neg_in     = diff_w[SUM_W-1];
            mag_in     = diff_w[SUM_W-1] ? MAG_W'(-diff_w) : MAG_W'(diff_w);
            state_in   = ST_MLO;
         end
         ST_MLO: begin
            mul_op.en = 1'b1;
            mul_op.a  = MUL_A_W'(mag_ff);
            mul_op.b  = MUL_B_W'(cfg.inv_track_width[15:0]);
            state_in  = ST_MHI;
         end
         ST_MHI: begin
            acc_in    = MAG_W'(mul_prod >> 16);
            mul_op.en = 1'b1;
            mul_op.a  = MUL_A_W'(mag_ff);
            mul_op.b  = MUL_B_W'(cfg.inv_track_width[31:16]);
            state_in  = ST_LIN;
         end
         ST_LIN: begin
            rot_raw_in = sat_avg(rate_s);
            d_w        = DIFF_W'(lin_raw_ff) - DIFF_W'(ylin_ff);
            mul_op.en  = 1'b1;
            mul_op.a   = MUL_A_W'(d_w);
            mul_op.b   = MUL_B_W'(alpha_lin);
            state_in   = ST_ROT;
         end
         ST_ROT: begin
            ema_sum   = WIDE_W'(ylin_ff) + tz16(mul_prod);
            ylin_in   = sat_avg(ema_sum);
            d_w       = DIFF_W'(rot_raw_ff) - DIFF_W'(yrot_ff);
            mul_op.en = 1'b1;
            mul_op.a  = MUL_A_W'(d_w);
            mul_op.b  = MUL_B_W'(alpha_rot);
            state_in  = ST_ML;
         end
         ST_ML: begin
            ema_sum   = WIDE_W'(yrot_ff) + tz16(mul_prod);
            yrot_in   = sat_avg(ema_sum);
            mul_op.en = 1'b1;
            mul_op.a  = MUL_A_W'(ylin_ff);
            mul_op.b  = MUL_B_W'(MILLI_SCALE);
            state_in  = ST_MR;
         end
         ST_MR: begin
            speed_milli_in = sat32(tz16(mul_prod));
            mul_op.en      = 1'b1;
            // filtered rotation inside the deadband reads as zero; state keeps it
            mul_op.a       = in_band ? '0 : MUL_A_W'(yrot_ff);
            mul_op.b       = MUL_B_W'(MILLI_SCALE);
            state_in       = ST_OUT;
         end
         ST_OUT: begin
            if (out_load) begin
               out_right_in = sat32(WIDE_W'(wr_ff));
               out_left_in  = wl_ff;
               out_speed_in = speed_milli_ff;
               out_rot_in   = sat32(tz16(mul_prod));
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         ylin_ff      <= '0;
         yrot_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         ylin_ff      <= ylin_in;
         yrot_ff      <= yrot_in;
      end
   end

   always_ff @(posedge clock) begin
      wr_ff          <= wr_in;
      wl_ff          <= wl_in;
      lin_raw_ff     <= lin_raw_in;
      mag_ff         <= mag_in;
      neg_ff         <= neg_in;
      acc_ff         <= acc_in;
      rot_raw_ff     <= rot_raw_in;
      speed_milli_ff <= speed_milli_in;
      out_right_ff   <= out_right_in;
      out_left_ff    <= out_left_in;
      out_speed_ff   <= out_speed_in;
      out_rot_ff     <= out_rot_in;
   end

   assign req_chan.ready               = (state_ff == ST_IDLE);
   assign rsp_chan.valid               = rsp_valid_ff;
   assign rsp_chan.right_wheel_speed   = out_right_ff;
   assign rsp_chan.left_wheel_speed    = out_left_ff;
   assign rsp_chan.body_speed_milli    = out_speed_ff;
   assign rsp_chan.body_rotation_milli = out_rot_ff;

endmodule

[rtl/diff_drive_speed_estimator.sv]
// A sample is taken only in IDLE and steps PREP, MLO, MHI, LIN, ROT, ML, MR, OUT;
//   OUT registers rsp valid, one beat per sample. A single shared 35x18 multiplier
//   is stepped through six products (rate low/high, two EMA weights, two x1000).
// A result waits in the output register while the next sample is taken in.
// Reset (synchronous, active high) clears both averages to zero, loads the
//   register defaults and drops rsp valid.
module diff_drive_speed_estimator
   import dds_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   dds_req_if.sink               req_chan,
   dds_rsp_if.source             rsp_chan,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   cfg_type                  cfg;
   mul_req_type              mul_op;
   logic signed [PROD_W-1:0] mul_prod;

   dds_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   dds_mul u_mul (
      .clock (clock),
      .op    (mul_op),
      .prod  (mul_prod)
   );

   dds_core u_core (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .mul_op   (mul_op),
      .mul_prod (mul_prod)
   );

endmodule

[rtl/dds_checker.sv]
module dds_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] rsp_right,
   input logic [31:0] rsp_left,
   input logic [31:0] rsp_speed,
   input logic [31:0] rsp_rot
);

   // a stalled result beat stays up
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("rsp valid dropped while stalled");

   // one sample at a time: input closes after each accepted beat
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("req ready high right after accept");

   // a new result appears only out of the busy sequence
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !$past(req_ready))
      else $error("result appeared while idle");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=>
         $stable(rsp_right) && $stable(rsp_left) && $stable(rsp_speed) && $stable(rsp_rot))
      else $error("rsp payload changed while stalled");

   assert property (@(posedge clock)
      $past(reset) |-> req_ready && !rsp_valid)
      else $error("bad state after reset");

endmodule

bind diff_drive_speed_estimator dds_checker u_dds_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_chan.valid),
   .req_ready (req_chan.ready),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .rsp_right (rsp_chan.right_wheel_speed),
   .rsp_left  (rsp_chan.left_wheel_speed),
   .rsp_speed (rsp_chan.body_speed_milli),
   .rsp_rot   (rsp_chan.body_rotation_milli)
);
